@@ src/linear_transform_tween_engine_assert.svh @@
`ifndef LINEAR_TRANSFORM_TWEEN_ENGINE_ASSERT_SVH
`define LINEAR_TRANSFORM_TWEEN_ENGINE_ASSERT_SVH

`ifndef SYNTH
`define LTTE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define LTTE_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define LTTE_ASSERT(lbl, clk, rst_n, prop)
`define LTTE_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

@@ src/ltte_pkg.sv @@
package ltte_pkg;

  localparam int unsigned AW = 5;

  localparam logic [16:0] ONE_Q16 = 17'h10000;
  localparam logic [23:0] ONE_U24 = 24'h010000;
  localparam logic [23:0] MAX_U24 = 24'hFFFFFF;
  localparam logic [1:0] MODE_LOOP = 2'd1;
  localparam logic [1:0] MODE_FADE = 2'd2;
  localparam logic [4:0] PROG_STEPS = 5'd16;
  localparam logic [4:0] RATIO_STEPS = 5'd24;

  typedef enum logic [1:0] {
    OP_TICK, OP_START, OP_STOP, OP_RESUME
  } opcode_t;

  typedef enum logic [2:0] {
    REG_MOVE_X, REG_MOVE_Y, REG_TURN, REG_SCALE_X,
    REG_SCALE_Y, REG_RUN_LEN, REG_MODE, REG_FINAL_ALPHA
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE, S_EVAL, S_DIVP, S_MUL, S_ACC, S_RSTART, S_RWAIT, S_DONE
  } state_t;

  typedef struct packed {
    logic signed [23:0] move_x;
    logic signed [23:0] move_y;
    logic signed [23:0] turn;
    logic [23:0] scale_x;
    logic [23:0] scale_y;
    logic [23:0] run_len;
    logic [1:0]  mode;
    logic [7:0]  final_alpha;
  } cfg_t;

  typedef struct packed {
    logic        start;
    logic [4:0]  steps;
    logic [23:0] rem;
    logic [23:0] low;
    logic [23:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [23:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic               applied;
    logic signed [23:0] move_x;
    logic signed [23:0] move_y;
    logic signed [23:0] turn;
    logic [23:0]        ratio_x;
    logic [23:0]        ratio_y;
    logic [7:0]         alpha;
    logic [16:0]        progress;
    logic               finished;
    logic               restarted;
  } res_t;

endpackage

@@ src/ltte_regs.sv @@
module ltte_regs
  import ltte_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [AW-1:0] paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output cfg_t          cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[AW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.move_x      <= '0;
      cfg_r.move_y      <= '0;
      cfg_r.turn        <= '0;
      cfg_r.scale_x     <= ONE_U24;
      cfg_r.scale_y     <= ONE_U24;
      cfg_r.run_len     <= '0;
      cfg_r.mode        <= '0;
      cfg_r.final_alpha <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_MOVE_X:      cfg_r.move_x      <= $signed(pwdata[23:0]);
        REG_MOVE_Y:      cfg_r.move_y      <= $signed(pwdata[23:0]);
        REG_TURN:        cfg_r.turn        <= $signed(pwdata[23:0]);
        REG_SCALE_X:     cfg_r.scale_x     <= pwdata[23:0];
        REG_SCALE_Y:     cfg_r.scale_y     <= pwdata[23:0];
        REG_RUN_LEN:     cfg_r.run_len     <= pwdata[23:0];
        REG_MODE:        cfg_r.mode        <= pwdata[1:0];
        REG_FINAL_ALPHA: cfg_r.final_alpha <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MOVE_X:      prdata = {8'd0, cfg_r.move_x};
      REG_MOVE_Y:      prdata = {8'd0, cfg_r.move_y};
      REG_TURN:        prdata = {8'd0, cfg_r.turn};
      REG_SCALE_X:     prdata = {8'd0, cfg_r.scale_x};
      REG_SCALE_Y:     prdata = {8'd0, cfg_r.scale_y};
      REG_RUN_LEN:     prdata = {8'd0, cfg_r.run_len};
      REG_MODE:        prdata = {30'd0, cfg_r.mode};
      REG_FINAL_ALPHA: prdata = {24'd0, cfg_r.final_alpha};
    endcase
  end

endmodule

@@ src/ltte_div.sv @@
module ltte_div
  import ltte_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [23:0] rem_r, low_r, dvs_r, quot_r;
  logic [4:0]  cnt_r;
  logic        busy_r, done_r;
  logic [24:0] trial, diff;
  logic        ge;

  assign trial = {rem_r, low_r[23]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= req.rem;
      low_r  <= req.low;
      dvs_r  <= req.divisor;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= ge ? diff[23:0] : trial[23:0];
      low_r  <= {low_r[22:0], 1'b0};
      quot_r <= {quot_r[22:0], ge};
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

@@ src/linear_transform_tween_engine.sv @@
// Linear keyframe tween engine.
// Commands arrive on the in_ channel (valid/ready): tick, start, stop or
// resume, each stamped with a millisecond time. Every accepted beat yields
// exactly one result beat on the out_ channel (valid/ready).
// Start, stop, resume and ticks while idle skip the arithmetic. An active
// tick runs five multiply and accumulate passes, a progress division and
// two scale ratio divisions, these only as needed; a fade tick runs only
// one pass. One shared restoring divider, one bit per cycle, and one 25 by
// 18 bit multiplier do the work. One command is in work at a time. The
// configuration is to be written over the APB-style port while the block
// is idle; the block itself does not enforce this. After reset the run is
// inactive and the configuration registers hold their reset values.
// If the receiver stalls, the finished result is held in the output
// register and the next command may still be accepted and computed; its
// result waits until the output register is free.
module linear_transform_tween_engine
  import ltte_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [AW-1:0]      paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_opcode,
  input  logic [31:0]        in_now_ms,
  input  logic [7:0]         in_current_alpha,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_applied,
  output logic signed [23:0] out_move_x,
  output logic signed [23:0] out_move_y,
  output logic signed [23:0] out_turn,
  output logic [23:0]        out_ratio_x,
  output logic [23:0]        out_ratio_y,
  output logic [7:0]         out_alpha_out,
  output logic [16:0]        out_progress,
  output logic               out_finished,
  output logic               out_restarted
);

`include "linear_transform_tween_engine_assert.svh"

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  ltte_regs u_regs (
    .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  ltte_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  state_t state_r, state_nxt;

  opcode_t            op_r;
  logic [31:0]        now_r;
  logic [7:0]         alpha_in_r;
  logic               active_r;
  logic [31:0]        begin_time_r;
  logic signed [23:0] last_x_r, last_y_r, last_t_r;
  logic [23:0]        last_sx_r, last_sy_r, new_sx_r, new_sy_r;
  logic [7:0]         begin_alpha_r;
  logic [16:0]        prog_r;
  logic [2:0]         idx_r;
  logic               rsel_r;
  logic               fin_r, restart_r;
  logic signed [42:0] prod_r;
  res_t               res_r, out_r;
  logic               out_valid_r;

  logic [31:0]        elapsed;
  logic               early, len_zero, reached, run_done, need_pdiv, fade, loops;
  logic               fire;
  logic               tick_act;
  logic signed [8:0]  d_alpha;
  logic signed [24:0] mul_a;
  logic signed [42:0] prod_sum;
  logic signed [26:0] lv;
  logic signed [23:0] last_sel;
  logic signed [27:0] diff;
  logic signed [23:0] diff_sat;
  logic [23:0]        r_old, r_new;
  logic               r_sat;

  assign elapsed   = now_r - begin_time_r;
  assign early     = elapsed[31];
  assign len_zero  = cfg.run_len == 24'd0;
  assign reached   = elapsed >= {8'd0, cfg.run_len};
  assign run_done  = !early && (len_zero || reached);
  assign need_pdiv = (op_r == OP_TICK) && active_r && !early && !run_done;
  assign fade      = cfg.mode == MODE_FADE;
  assign loops     = cfg.mode == MODE_LOOP;
  assign fire      = !out_valid_r || out_ready;
  assign tick_act  = (op_r == OP_TICK) && active_r;

  assign d_alpha = $signed({1'b0, cfg.final_alpha}) - $signed({1'b0, begin_alpha_r});

  always_comb begin
    case (idx_r)
      3'd0: mul_a = fade ? {{16{d_alpha[8]}}, d_alpha} : {cfg.move_x[23], cfg.move_x};
      3'd1: mul_a = {cfg.move_y[23], cfg.move_y};
      3'd2: mul_a = {cfg.turn[23], cfg.turn};
      3'd3: mul_a = $signed({1'b0, cfg.scale_x} - {1'b0, ONE_U24});
      default: mul_a = $signed({1'b0, cfg.scale_y} - {1'b0, ONE_U24});
    endcase
  end

  assign prod_sum = prod_r + (prod_r[42] ? 43'sd65535 : 43'sd0);
  assign lv       = $signed(prod_sum[42:16]);

  always_comb begin
    case (idx_r)
      3'd0:    last_sel = last_x_r;
      3'd1:    last_sel = last_y_r;
      default: last_sel = last_t_r;
    endcase
  end

  assign diff = $signed({lv[26], lv}) - $signed({{4{last_sel[23]}}, last_sel});

  always_comb begin
    if (diff > 28'sd8388607) begin
      diff_sat = 24'sh7FFFFF;
    end else if (diff < -28'sd8388608) begin
      diff_sat = 24'sh800000;
    end else begin
      diff_sat = diff[23:0];
    end
  end

  assign r_old = rsel_r ? last_sy_r : last_sx_r;
  assign r_new = rsel_r ? new_sy_r : new_sx_r;
  assign r_sat = (r_old == 24'd0) || ({8'd0, r_new} >= {r_old, 8'd0});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    div_req.start   = 1'b0;
    div_req.steps   = PROG_STEPS;
    div_req.rem     = elapsed[23:0];
    div_req.low     = '0;
    div_req.divisor = cfg.run_len;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (need_pdiv) begin
          div_req.start = 1'b1;
          state_nxt = S_DIVP;
        end else if ((op_r == OP_TICK) && active_r) begin
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DIVP: begin
        if (div_rsp.done) state_nxt = S_MUL;
      end
      S_MUL: state_nxt = S_ACC;
      S_ACC: begin
        if (fade) begin
          state_nxt = S_DONE;
        end else if (idx_r == 3'd4) begin
          state_nxt = S_RSTART;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_RSTART: begin
        div_req.steps   = RATIO_STEPS;
        div_req.rem     = {8'd0, r_new[23:8]};
        div_req.low     = {r_new[7:0], 16'd0};
        div_req.divisor = r_old;
        if (!r_sat) begin
          div_req.start = 1'b1;
          state_nxt = S_RWAIT;
        end else if (rsel_r) begin
          state_nxt = S_DONE;
        end
      end
      S_RWAIT: begin
        if (div_rsp.done) state_nxt = rsel_r ? S_DONE : S_RSTART;
      end
      S_DONE: begin
        if (fire) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ready = state_r == S_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r      <= 1'b0;
      begin_time_r  <= '0;
      last_x_r      <= '0;
      last_y_r      <= '0;
      last_t_r      <= '0;
      last_sx_r     <= ONE_U24;
      last_sy_r     <= ONE_U24;
      begin_alpha_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r       <= opcode_t'(in_opcode);
            now_r      <= in_now_ms;
            alpha_in_r <= in_current_alpha;
          end
        end
        S_EVAL: begin
          res_r.applied   <= tick_act;
          res_r.move_x    <= '0;
          res_r.move_y    <= '0;
          res_r.turn      <= '0;
          res_r.ratio_x   <= ONE_U24;
          res_r.ratio_y   <= ONE_U24;
          res_r.alpha     <= '0;
          res_r.progress  <= ((op_r == OP_TICK) && !active_r) ? ONE_Q16 : 17'd0;
          res_r.finished  <= tick_act && run_done && !loops;
          res_r.restarted <= tick_act && run_done && loops;
          fin_r           <= tick_act && run_done && !loops;
          restart_r       <= tick_act && run_done && loops;
          idx_r           <= '0;
          rsel_r          <= 1'b0;
          prog_r          <= early ? 17'd0 : ONE_Q16;
          unique case (op_r)
            OP_START: begin
              active_r      <= 1'b1;
              begin_time_r  <= now_r;
              last_x_r      <= '0;
              last_y_r      <= '0;
              last_t_r      <= '0;
              last_sx_r     <= ONE_U24;
              last_sy_r     <= ONE_U24;
              begin_alpha_r <= alpha_in_r;
            end
            OP_STOP:   active_r <= 1'b0;
            OP_RESUME: active_r <= 1'b1;
            default: ;
          endcase
        end
        S_DIVP: begin
          if (div_rsp.done) prog_r <= {1'b0, div_rsp.quot[15:0]};
        end
        S_MUL: begin
          prod_r         <= mul_a * $signed({1'b0, prog_r});
          res_r.progress <= prog_r;
        end
        S_ACC: begin
          idx_r <= idx_r + 3'd1;
          if (fade) begin
            res_r.alpha <= begin_alpha_r + lv[7:0];
          end else begin
            case (idx_r)
              3'd0: begin
                res_r.move_x <= diff_sat;
                last_x_r     <= lv[23:0];
              end
              3'd1: begin
                res_r.move_y <= diff_sat;
                last_y_r     <= lv[23:0];
              end
              3'd2: begin
                res_r.turn <= diff_sat;
                last_t_r   <= lv[23:0];
              end
              3'd3:    new_sx_r <= ONE_U24 + lv[23:0];
              default: new_sy_r <= ONE_U24 + lv[23:0];
            endcase
          end
        end
        S_RSTART: begin
          if (r_sat) begin
            rsel_r <= 1'b1;
            if (rsel_r) begin
              res_r.ratio_y <= MAX_U24;
              last_sy_r     <= new_sy_r;
            end else begin
              res_r.ratio_x <= MAX_U24;
              last_sx_r     <= new_sx_r;
            end
          end
        end
        S_RWAIT: begin
          if (div_rsp.done) begin
            rsel_r <= 1'b1;
            if (rsel_r) begin
              res_r.ratio_y <= div_rsp.quot;
              last_sy_r     <= new_sy_r;
            end else begin
              res_r.ratio_x <= div_rsp.quot;
              last_sx_r     <= new_sx_r;
            end
          end
        end
        S_DONE: begin
          if (fire) begin
            out_r <= res_r;
            if (fin_r) active_r <= 1'b0;
            if (restart_r) begin
              active_r      <= 1'b1;
              begin_time_r  <= now_r;
              last_x_r      <= '0;
              last_y_r      <= '0;
              last_t_r      <= '0;
              last_sx_r     <= ONE_U24;
              last_sy_r     <= ONE_U24;
              begin_alpha_r <= alpha_in_r;
            end
          end
        end
        default: ;
      endcase
      if ((state_r == S_DONE) && fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_applied   = out_r.applied;
  assign out_move_x    = out_r.move_x;
  assign out_move_y    = out_r.move_y;
  assign out_turn      = out_r.turn;
  assign out_ratio_x   = out_r.ratio_x;
  assign out_ratio_y   = out_r.ratio_y;
  assign out_alpha_out = out_r.alpha;
  assign out_progress  = out_r.progress;
  assign out_finished  = out_r.finished;
  assign out_restarted = out_r.restarted;

  `LTTE_ASSERT(a_div_done_waited, clk, rst_n,
               div_rsp.done |-> (state_r == S_DIVP || state_r == S_RWAIT))
  `LTTE_ASSERT(a_progress_range, clk, rst_n, out_valid |-> (out_progress <= ONE_Q16))
  `LTTE_NEVER(a_fin_and_restart, clk, rst_n, out_valid && out_finished && out_restarted)
  `LTTE_NEVER(a_div_start_busy, clk, rst_n, div_req.start && div_rsp.busy)

endmodule
